>>> design/b64fu_pkg.sv
package b64fu_pkg;

   // Widths fixed by the item fields.
   localparam int CHAR_W    = 8;
   localparam int CODE_W    = 6;
   localparam int LIMIT_W   = 12;
   localparam int INDEX_W   = 11;
   localparam int WORD_W    = 32;
   localparam int ACC_W     = 12;
   localparam int PEND_W    = 4;
   localparam int GATHER_W  = 24;
   localparam int RSP_DATA_W = 80;

   // Largest frame in samples; the pixel count register is clamped to this.
   localparam int MAX_PIXELS = 2048;

   // Pixel count after reset.
   localparam logic [LIMIT_W-1:0] PIXEL_COUNT_RESET = 12'd256;

   // Queue between the classifier and the decoder.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Largest bit pattern that may raise the running maximum (positive infinity).
   localparam logic [WORD_W-1:0] POS_INF_BITS = 32'h7F80_0000;

   // One classified input item.
   typedef struct packed {
      logic              bad;
      logic [CODE_W-1:0] code;
      logic              start;
      logic              final_char;
   } item_type;

   // Base64 alphabet of this link: '-' and '_' both give 63, '<' gives 0.
   function automatic logic [CODE_W:0] decode_char(input logic [CHAR_W-1:0] ch);
      logic [CODE_W:0] res;
      res = {1'b1, {CODE_W{1'b0}}};
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         res = {1'b0, 6'(ch - 8'h41)};
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         res = {1'b0, 6'(ch - 8'h47)};
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         res = {1'b0, 6'(ch + 8'h04)};
      end else if (ch == 8'h2B) begin
         res = {1'b0, 6'd62};
      end else if (ch == 8'h2D || ch == 8'h5F) begin
         res = {1'b0, 6'd63};
      end else if (ch == 8'h3C) begin
         res = {1'b0, 6'd0};
      end
      return res;
   endfunction

endpackage

>>> design/b64fu_front.sv
module b64fu_front (
   input  logic [b64fu_pkg::CHAR_W-1:0] character,
   input  logic                         frame_start,
   input  logic                         frame_final,
   output b64fu_pkg::item_type          item
);

   logic [b64fu_pkg::CODE_W:0] decoded;

   // Look the character up and tag it with its frame flags.
   always_comb begin
      decoded         = b64fu_pkg::decode_char(character);
      item.bad        = decoded[b64fu_pkg::CODE_W];
      item.code       = decoded[b64fu_pkg::CODE_W-1:0];
      item.start      = frame_start;
      item.final_char = frame_final;
   end

endmodule

>>> design/b64fu_queue.sv
module b64fu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64fu_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output b64fu_pkg::item_type pop_item
);

   localparam int PW = b64fu_pkg::QUEUE_PTR_W;
   localparam int CW = PW + 1;

   b64fu_pkg::item_type      entry_ff [b64fu_pkg::QUEUE_DEPTH];
   logic [PW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]            count_ff, count_in;

   assign full      = (count_ff == CW'(b64fu_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = PW'((CW'(wr_ptr_ff) + CW'(1)) % CW'(b64fu_pkg::QUEUE_DEPTH));
      end
      if (pop) begin
         rd_ptr_in = PW'((CW'(rd_ptr_ff) + CW'(1)) % CW'(b64fu_pkg::QUEUE_DEPTH));
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/b64fu_back.sv
module b64fu_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [b64fu_pkg::LIMIT_W-1:0]         csr_wr_data,
   input  logic                                  item_valid,
   input  b64fu_pkg::item_type                   item,
   output logic                                  item_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_has_sample,
   output logic [b64fu_pkg::WORD_W-1:0]          rsp_sample_bits,
   output logic [b64fu_pkg::INDEX_W-1:0]         rsp_sample_index,
   output logic [b64fu_pkg::WORD_W-1:0]          rsp_running_max,
   output logic                                  rsp_frame_done
);

   localparam int LW = b64fu_pkg::LIMIT_W;
   localparam logic [31:0] MAX_P = 32'(b64fu_pkg::MAX_PIXELS);

   // Frame limit, held already clamped.
   logic [LW-1:0] limit_ff, limit_in;

   // Decoder state.
   logic [b64fu_pkg::ACC_W-1:0]           acc_ff, acc_in, acc_eff;
   logic signed [b64fu_pkg::PEND_W-1:0]   pend_ff, pend_in, pend_eff, pend_sum;
   logic [b64fu_pkg::GATHER_W-1:0]        gather_ff, gather_in, gather_eff;
   logic [1:0]                            pos_ff, pos_in, pos_eff;
   logic [LW-1:0]                         count_ff, count_in, count_eff, count_inc;
   logic [b64fu_pkg::WORD_W-1:0]          max_ff, max_in, max_eff;
   logic                                  stopped_ff, stopped_in, stopped_eff;

   // Output register.
   logic                                  out_valid_ff, out_valid_in;
   logic                                  out_have_ff, out_have_in;
   logic [b64fu_pkg::WORD_W-1:0]          out_word_ff, out_word_in;
   logic [b64fu_pkg::INDEX_W-1:0]         out_index_ff, out_index_in;
   logic [b64fu_pkg::WORD_W-1:0]          out_max_ff, out_max_in;
   logic                                  out_done_ff, out_done_in;

   logic [b64fu_pkg::ACC_W-1:0]           acc_new;
   logic [7:0]                            byte_val;
   logic [b64fu_pkg::WORD_W-1:0]          word;
   logic                                  have;
   logic                                  done;

   // The next item may enter whenever the output register is free or being emptied.
   assign item_pop = item_valid && (!out_valid_ff || rsp_ready);

   // Pixel count register, clamped to the range one to MAX_PIXELS.
   always_comb begin
      limit_in = limit_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            limit_in = LW'(1);
         end else if (32'(csr_wr_data) > MAX_P) begin
            limit_in = LW'(MAX_P);
         end else begin
            limit_in = csr_wr_data;
         end
      end
   end

   // Decode one character against the state, cleared first on a frame start.
   always_comb begin
      if (item.start) begin
         acc_eff     = '0;
         pend_eff    = -4'sd8;
         gather_eff  = '0;
         pos_eff     = '0;
         count_eff   = '0;
         max_eff     = '0;
         stopped_eff = 1'b0;
      end else begin
         acc_eff     = acc_ff;
         pend_eff    = pend_ff;
         gather_eff  = gather_ff;
         pos_eff     = pos_ff;
         count_eff   = count_ff;
         max_eff     = max_ff;
         stopped_eff = stopped_ff;
      end

      acc_new   = {acc_eff[b64fu_pkg::ACC_W-7:0], item.code};
      pend_sum  = pend_eff + 4'sd6;
      byte_val  = 8'(acc_new >> pend_sum[2:0]);
      word      = {byte_val, gather_eff};
      count_inc = count_eff + LW'(1);

      acc_in     = acc_eff;
      pend_in    = pend_eff;
      gather_in  = gather_eff;
      pos_in     = pos_eff;
      count_in   = count_eff;
      max_in     = max_eff;
      stopped_in = stopped_eff;
      have       = 1'b0;
      done       = 1'b0;

      if (!stopped_eff) begin
         if (item.bad) begin
            done = 1'b1;
         end else begin
            acc_in  = acc_new;
            pend_in = pend_sum;
            if (!pend_sum[b64fu_pkg::PEND_W-1]) begin
               // A whole byte is ready.
               pend_in = pend_sum - 4'sd8;
               if (pos_eff == 2'd3) begin
                  gather_in = '0;
                  pos_in    = '0;
                  have      = 1'b1;
                  count_in  = count_inc;
                  if (word != '0 && word <= b64fu_pkg::POS_INF_BITS && word > max_eff) begin
                     max_in = word;
                  end
                  if (count_inc >= limit_ff) begin
                     done = 1'b1;
                  end
               end else begin
                  case (pos_eff)
                     2'd0:    gather_in = {gather_eff[23:8], byte_val};
                     2'd1:    gather_in = {gather_eff[23:16], byte_val, gather_eff[7:0]};
                     default: gather_in = {byte_val, gather_eff[15:0]};
                  endcase
                  pos_in = pos_eff + 2'd1;
               end
            end
            if (item.final_char) begin
               done = 1'b1;
            end
         end
      end
      if (done) begin
         stopped_in = 1'b1;
      end
   end

   // Load the output register when an item produces a result.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_have_in  = out_have_ff;
      out_word_in  = out_word_ff;
      out_index_in = out_index_ff;
      out_max_in   = out_max_ff;
      out_done_in  = out_done_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (item_pop && (have || done)) begin
         out_valid_in = 1'b1;
         out_have_in  = have;
         out_word_in  = have ? word : '0;
         out_index_in = have ? count_eff[b64fu_pkg::INDEX_W-1:0] : '0;
         out_max_in   = max_in;
         out_done_in  = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= b64fu_pkg::PIXEL_COUNT_RESET;
         acc_ff       <= '0;
         pend_ff      <= -4'sd8;
         gather_ff    <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         max_ff       <= '0;
         stopped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         out_valid_ff <= out_valid_in;
         if (item_pop) begin
            acc_ff     <= acc_in;
            pend_ff    <= pend_in;
            gather_ff  <= gather_in;
            pos_ff     <= pos_in;
            count_ff   <= count_in;
            max_ff     <= max_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      out_have_ff  <= out_have_in;
      out_word_ff  <= out_word_in;
      out_index_ff <= out_index_in;
      out_max_ff   <= out_max_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_has_sample   = out_have_ff;
   assign rsp_sample_bits  = out_word_ff;
   assign rsp_sample_index = out_index_ff;
   assign rsp_running_max  = out_max_ff;
   assign rsp_frame_done   = out_done_ff;

endmodule

>>> design/base64_float_sample_unpacker_core.sv
// Channel    Direction  Handshake               Contents
// req_       in         req_tvalid/req_tready   one base64 character with frame flags
// rsp_       out        rsp_tvalid/rsp_tready   float sample, index, running maximum
// csr_       in         csr_wr_en               pixel count (12 bits)
//
// One item is accepted per cycle while req_tready is high; a result passes
// through the four-entry queue and then the output register.
// The decoder updates its state once per item, so the rate is
// one item per clock while rsp_tready stays high.
// Reset is synchronous and sets the pixel count to 256 and clears all frame state.
// A stall on the result side fills the queue; req_tready falls once it is full.
module base64_float_sample_unpacker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // character[7:0]
   input  logic        req_tuser,  // frame_start
   input  logic        req_tlast,  // frame_final
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // sample_bits[31:0], sample_index[42:32],
                                   // running_max_bits[74:43], zero fill[79:75]
   output logic        rsp_tuser,  // has_sample
   output logic        rsp_tlast,  // frame_done
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data
);

   b64fu_pkg::item_type front_item;
   b64fu_pkg::item_type queue_item;
   logic                queue_full;
   logic                queue_not_empty;
   logic                queue_pop;
   logic                req_accept;
   logic [31:0]         sample_bits;
   logic [10:0]         sample_index;
   logic [31:0]         running_max;

   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   // Classify the incoming character.
   b64fu_front u_front (
      .character   (req_tdata),
      .frame_start (req_tuser),
      .frame_final (req_tlast),
      .item        (front_item)
   );

   // Queue between the classifier and the decoder.
   b64fu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_item  (queue_item)
   );

   // Bit stream decoding, word assembly and result register.
   b64fu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .item_valid       (queue_not_empty),
      .item             (queue_item),
      .item_pop         (queue_pop),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_has_sample   (rsp_tuser),
      .rsp_sample_bits  (sample_bits),
      .rsp_sample_index (sample_index),
      .rsp_running_max  (running_max),
      .rsp_frame_done   (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, running_max, sample_index, sample_bits};

   // A result without a sample always ends its frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("result without sample does not end the frame");

   // A result without a sample carries zero sample bits and index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[42:0] == 43'd0)
      else $error("empty result carries sample data");

   // The running maximum never holds a negative or NaN pattern.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[74:43] <= b64fu_pkg::POS_INF_BITS)
      else $error("running maximum out of range");

endmodule
